@@ hdl/positional_list_insert_delete_defines.svh @@
// Assertion helpers for the positional list checker.
`ifndef POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PLID_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("plid checker: implication failed");

// next-cycle implication, disabled in reset
`define PLID_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("plid checker: next-cycle implication failed");

`endif

@@ hdl/plid_pkg.sv @@
`default_nettype none

package plid_pkg;

	localparam int LIST_DEPTH = 64;

	localparam int POS_W = 8;
	localparam int VAL_W = 32;
	localparam int LEN_W = 7;

	localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	// wide enough for both a slot number and a position
	localparam int CMP_W = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int EXT_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_DELETE = 1'b1;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic                    ins;
		logic                    del;
		logic [CMP_W-1:0]        idx;
		logic signed [VAL_W-1:0] value;
	} plid_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/plid_cell.sv @@
`default_nettype none

module plid_cell (
	input  logic                              clk,
	input  plid_pkg::plid_ctrl_t              ctrl,
	input  logic [plid_pkg::CMP_W-1:0]        slot,
	input  logic signed [plid_pkg::VAL_W-1:0] prev_val,
	input  logic signed [plid_pkg::VAL_W-1:0] next_val,
	output logic signed [plid_pkg::VAL_W-1:0] val,
	output logic signed [plid_pkg::VAL_W-1:0] pick
);
	import plid_pkg::*;

	logic signed [VAL_W-1:0] val_q;

	// insert: slots above the target take the lower neighbor, target takes the new value
	// delete: target and above take the upper neighbor
	always_ff @(posedge clk) begin
		priority if (ctrl.ins && (slot > ctrl.idx)) begin
			val_q <= prev_val;
		end else if (ctrl.ins && (slot == ctrl.idx)) begin
			val_q <= ctrl.value;
		end else if (ctrl.del && (slot >= ctrl.idx)) begin
			val_q <= next_val;
		end else begin
			val_q <= val_q;
		end
	end

	assign val  = val_q;
	assign pick = (slot == ctrl.idx) ? val_q : '0;

endmodule

`default_nettype wire

@@ hdl/positional_list_insert_delete.sv @@
`default_nettype none

// Positional list: ordered list of signed 32-bit values, LIST_DEPTH entries max.
// Request channel: start with kind/position/value; taken at a clock edge where
// start is high and busy is low. busy never rises, so a request may be issued
// every cycle.
// kind = insert: value goes to 1-based position p (1 <= p <= count+1, list not
// full), later entries move up one slot.
// kind = delete: entry at p (1 <= p <= count) is returned, later entries move
// down one slot.
// Result channel: done pulses for one cycle, the cycle after the request edge,
// with ok, removed_value (zero unless a delete succeeded) and length (entry
// count after the request, low 7 bits). Throughput 1 per cycle, set by the cell
// chain, which shifts every entry in parallel.
// The receiver cannot stall; a result not taken in its cycle is gone.
// Reset (arst_n low) empties the list and drops any pending result; entry
// contents are not cleared, only the count.
module positional_list_insert_delete (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              kind,
	input  logic [plid_pkg::POS_W-1:0]        position,
	input  logic signed [plid_pkg::VAL_W-1:0] value,
	output logic                              done,
	output logic                              ok,
	output logic signed [plid_pkg::VAL_W-1:0] removed_value,
	output logic [plid_pkg::LEN_W-1:0]        length
);
	import plid_pkg::*;

	logic [CNT_W-1:0]        count_q;
	logic                    done_q;
	logic                    ok_q;
	logic signed [VAL_W-1:0] removed_q;

	logic [EXT_W-1:0]        pos_e;
	logic [EXT_W-1:0]        cnt_e;
	logic                    pos_nz;
	logic                    ins_ok;
	logic                    del_ok;
	plid_ctrl_t              ctrl;
	logic signed [VAL_W-1:0] picked;

	logic signed [VAL_W-1:0] vals  [LIST_DEPTH];
	logic signed [VAL_W-1:0] picks [LIST_DEPTH];

	// request always taken
	assign busy = 1'b0;

	// position checks against the current count
	assign pos_e  = EXT_W'(position);
	assign cnt_e  = EXT_W'(count_q);
	assign pos_nz = (position != '0);
	assign ins_ok = start && (kind == KIND_INSERT) && pos_nz
		&& (pos_e <= cnt_e + EXT_W'(1)) && (count_q < CNT_W'(LIST_DEPTH));
	assign del_ok = start && (kind == KIND_DELETE) && pos_nz && (pos_e <= cnt_e);

	// broadcast to the chain: zero-based target slot
	assign ctrl.ins   = ins_ok;
	assign ctrl.del   = del_ok;
	assign ctrl.idx   = CMP_W'(position) - CMP_W'(1);
	assign ctrl.value = value;

	// cell i holds list entry i; neighbors feed each other for the shifts
	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		logic signed [VAL_W-1:0] prev_v;
		logic signed [VAL_W-1:0] next_v;

		if (i == 0) begin : g_first
			assign prev_v = value;
		end else begin : g_mid_lo
			assign prev_v = vals[i-1];
		end

		if (i == LIST_DEPTH - 1) begin : g_last
			assign next_v = vals[i];
		end else begin : g_mid_hi
			assign next_v = vals[i+1];
		end

		plid_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.slot     (CMP_W'(i)),
			.prev_val (prev_v),
			.next_val (next_v),
			.val      (vals[i]),
			.pick     (picks[i])
		);
	end

	// only the target cell drives a nonzero pick
	always_comb begin
		picked = '0;
		for (int k = 0; k < LIST_DEPTH; k++) begin
			picked = picked | picks[k];
		end
	end

	// count and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
			ok_q    <= 1'b0;
		end else begin
			done_q <= start;
			ok_q   <= ins_ok || del_ok;
			if (ins_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (del_ok) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		removed_q <= del_ok ? picked : '0;
	end

	assign done          = done_q;
	assign ok            = ok_q;
	assign removed_value = removed_q;
	assign length        = LEN_W'(count_q);

endmodule

`default_nettype wire

@@ hdl/plid_checker.sv @@
`default_nettype none

`include "positional_list_insert_delete_defines.svh"

module plid_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              kind,
	input logic                              done,
	input logic                              ok,
	input logic signed [plid_pkg::VAL_W-1:0] removed_value,
	input logic [plid_pkg::LEN_W-1:0]        length
);
	import plid_pkg::*;

	// every request gives one result the next cycle
	`PLID_ASSERT_NXT(a_req_result, start && !busy, done)
	`PLID_ASSERT_IMP(a_result_req, done, $past(start && !busy))
	// a failed request leaves the length alone
	`PLID_ASSERT_IMP(a_fail_len, done && !ok, length == $past(length))
	// a good insert grows the list by one
	`PLID_ASSERT_IMP(a_ins_len, done && ok && ($past(kind) == KIND_INSERT),
		length == LEN_W'($past(length) + LEN_W'(1)))
	// only a good delete returns a value
	`PLID_ASSERT_IMP(a_rm_zero, done && (!ok || ($past(kind) == KIND_INSERT)),
		removed_value == '0)

endmodule

bind positional_list_insert_delete plid_checker u_plid_checker (.*);

`default_nettype wire

@@ dv/positional_list_insert_delete_tb.sv @@
`timescale 1ns / 1ps

module positional_list_insert_delete_tb;

	import plid_pkg::*;

	// watchdog: a loose bound on the length of the run
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_ITEMS = 1900;
	localparam int SETTLE_CYCLES = 8;

	// one request as the driver presents it; hold_for_drain makes the driver
	// wait with start low until every outstanding result has been checked
	typedef struct packed {
		logic                    op;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] val;
		logic                    hold_for_drain;
	} list_req_t;

	// one result as the block reports it
	typedef struct packed {
		logic                    ok;
		logic signed [VAL_W-1:0] removed;
		logic [LEN_W-1:0]        len;
	} list_result_t;

	// shape of a stretch of random traffic
	typedef enum int {
		PH_FILL,
		PH_DRAIN,
		PH_MIX
	} phase_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    kind = KIND_INSERT;
	logic [POS_W-1:0]        position = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic                    busy;
	logic                    done;
	logic                    ok;
	logic signed [VAL_W-1:0] removed_value;
	logic [LEN_W-1:0]        length;

	list_req_t    pend_q[$];      // requests waiting to be driven
	list_result_t expected_q[$];  // predicted results, oldest first

	// predictor state: our own image of the list
	logic signed [VAL_W-1:0] list_mem[LIST_DEPTH];
	int                      list_len = 0;

	// entry count as the stimulus generator sees it, used only to aim positions
	int gen_len = 0;

	int gap_left = 0;
	int burst_left = 1;
	int error_count = 0;
	int cycle_count = 0;

	positional_list_insert_delete dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.position     (position),
		.value        (value),
		.done         (done),
		.ok           (ok),
		.removed_value(removed_value),
		.length       (length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one accepted request to the list image and return what the block
	// should report. Failed requests leave the list untouched and report ok and removed as zero.
	function automatic list_result_t apply_request(input logic op,
			input logic [POS_W-1:0] pos, input logic signed [VAL_W-1:0] val);
		list_result_t r;
		int p;
		int k;
		p = pos;
		r.ok = 1'b0;
		r.removed = '0;
		if (op == KIND_INSERT) begin
			// room needed, and p may sit one past the tail
			if (p >= 1 && p <= list_len + 1 && list_len < LIST_DEPTH) begin
				for (k = list_len; k > p - 1; k--)
					list_mem[k] = list_mem[k - 1];
				list_mem[p - 1] = val;
				list_len++;
				r.ok = 1'b1;
			end
		end else begin
			if (p >= 1 && p <= list_len) begin
				r.removed = list_mem[p - 1];
				for (k = p - 1; k + 1 < list_len; k++)
					list_mem[k] = list_mem[k + 1];
				list_len--;
				r.ok = 1'b1;
			end
		end
		r.len = LEN_W'(list_len);
		return r;
	endfunction

	// Queue a request and track the count so later positions can be aimed.
	task automatic queue_request(input logic op, input int pos,
			input logic signed [VAL_W-1:0] val, input logic drain);
		list_req_t r;
		r.op = op;
		r.pos = POS_W'(pos);
		r.val = val;
		r.hold_for_drain = drain;
		pend_q.push_back(r);
		if (op == KIND_INSERT) begin
			if (pos >= 1 && pos <= gen_len + 1 && gen_len < LIST_DEPTH)
				gen_len++;
		end else if (pos >= 1 && pos <= gen_len) begin
			gen_len--;
		end
	endtask

	// Random value with the bit extremes showing up now and then.
	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return '1;
			2: return {1'b1, {(VAL_W-1){1'b0}}};
			3: return {1'b0, {(VAL_W-1){1'b1}}};
			default: return $urandom;
		endcase
	endfunction

	// Position for an op whose last legal position is top: mostly legal and
	// leaning on the ends, sometimes zero or past the end.
	function automatic int pick_position(input int top);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 3)
			return 0;
		if (sel < 5)
			return 255;
		if (sel < 9 || top == 0)
			return $urandom_range(top + 1, 255);
		if (sel < 25)
			return 1;
		if (sel < 41)
			return top;
		return $urandom_range(1, top);
	endfunction

	// Driver: the predictor runs on each accepted request (start high, busy low
	// at this edge), then the next request or an idle cycle is set up. Each
	// signal gets a single nonblocking update per edge.
	always @(posedge clk) begin : driver
		list_req_t nxt;
		if (start && !busy)
			expected_q.push_back(apply_request(kind, position, value));
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && busy)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pend_q.size() == 0) begin
				start <= 1'b0;
			end else if (pend_q[0].hold_for_drain && expected_q.size() != 0) begin
				// pause with nothing in flight before this request
				start <= 1'b0;
			end else begin
				nxt = pend_q.pop_front();
				start <= 1'b1;
				kind <= nxt.op;
				position <= nxt.pos;
				value <= nxt.val;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					// new burst; many gaps are zero so long back-to-back runs occur
					burst_left = $urandom_range(1, 48);
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4: gap_left = 0;
						5, 6, 7:       gap_left = $urandom_range(1, 3);
						8:             gap_left = $urandom_range(4, 10);
						default:       gap_left = $urandom_range(11, 24);
					endcase
				end
			end
		end
	end

	// Monitor: done marks a one-cycle result, taken at the edge that ends it.
	always @(posedge clk) begin : monitor
		list_result_t want;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$display("%0t: result with none expected: ok=%0b removed=%0d length=%0d",
					$time, ok, removed_value, length);
				error_count++;
			end else begin
				want = expected_q.pop_front();
				if (ok !== want.ok) begin
					$display("%0t: ok mismatch: expected %0b actual %0b",
						$time, want.ok, ok);
					error_count++;
				end
				if (removed_value !== want.removed) begin
					$display("%0t: removed_value mismatch: expected %0d actual %0d",
						$time, want.removed, removed_value);
					error_count++;
				end
				if (length !== want.len) begin
					$display("%0t: length mismatch: expected %0d actual %0d",
						$time, want.len, length);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : stimulus
		phase_t phase;
		int phase_left;
		int n;
		int ins_pct;
		logic op;

		// directed: empty-list failures first
		queue_request(KIND_DELETE, 1, pick_value(), 1'b0);   // delete from empty
		queue_request(KIND_INSERT, 0, 32'sd5, 1'b0);         // position zero
		queue_request(KIND_INSERT, 2, 32'sd6, 1'b0);         // past count+1
		queue_request(KIND_INSERT, 255, 32'sd7, 1'b0);       // all position bits set
		// build [-1, 0, 0x55555555, max, min, 0xaaaaaaaa]
		queue_request(KIND_INSERT, 1, 32'sh7fffffff, 1'b0);
		queue_request(KIND_INSERT, 2, 32'sh80000000, 1'b0);  // append
		queue_request(KIND_INSERT, 1, -32'sd1, 1'b0);        // head
		queue_request(KIND_INSERT, 2, 32'sd0, 1'b0);         // middle
		queue_request(KIND_INSERT, 3, 32'sh55555555, 1'b0);
		queue_request(KIND_INSERT, 6, 32'shaaaaaaaa, 1'b0);  // at count+1
		queue_request(KIND_INSERT, 8, 32'sd9, 1'b0);         // count+2 fails
		// delete failures on a non-empty list
		queue_request(KIND_DELETE, 0, pick_value(), 1'b0);
		queue_request(KIND_DELETE, 7, pick_value(), 1'b0);   // count+1
		queue_request(KIND_DELETE, 255, pick_value(), 1'b0);
		// head, tail, middle, then empty it out
		queue_request(KIND_DELETE, 1, pick_value(), 1'b0);
		queue_request(KIND_DELETE, 5, pick_value(), 1'b0);
		queue_request(KIND_DELETE, 2, pick_value(), 1'b0);
		queue_request(KIND_DELETE, 1, pick_value(), 1'b0);
		queue_request(KIND_DELETE, 2, pick_value(), 1'b0);
		queue_request(KIND_DELETE, 1, pick_value(), 1'b0);
		queue_request(KIND_DELETE, 1, pick_value(), 1'b0);   // delete from empty again

		// random: fill/drain/mix phases so the list swings between empty and
		// full, with inserts into a full list while filling; the first random
		// request always waits for a drained pipe
		n = 0;
		phase_left = 0;
		phase = PH_FILL;
		while (n < RANDOM_ITEMS) begin
			if (phase_left == 0) begin
				case ($urandom_range(0, 2))
					0:       phase = PH_FILL;
					1:       phase = PH_DRAIN;
					default: phase = PH_MIX;
				endcase
				phase_left = $urandom_range(40, 200);
			end
			case (phase)
				PH_FILL:  ins_pct = 85;
				PH_DRAIN: ins_pct = 15;
				default:  ins_pct = 50;
			endcase
			op = ($urandom_range(0, 99) < ins_pct) ? KIND_INSERT : KIND_DELETE;
			queue_request(op, pick_position(op == KIND_INSERT ? gen_len + 1 : gen_len),
				pick_value(), n == 0 || ($urandom_range(0, 99) == 0));
			n++;
			phase_left--;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// everything driven and accepted, nothing still owed
		while (pend_q.size() != 0 || start || expected_q.size() != 0)
			@(posedge clk);
		// settle time to catch a stray done
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hdl
hdl/plid_pkg.sv
hdl/plid_cell.sv
hdl/positional_list_insert_delete.sv
hdl/plid_checker.sv
dv/positional_list_insert_delete_tb.sv
